FILE: design/fp32_gemv_row_stream_unit_assert.svh
// Assertion macros for the row-stream matrix-vector unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FP32_GEMV_ROW_STREAM_UNIT_ASSERT_SVH
`define FP32_GEMV_ROW_STREAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FGEMV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FGEMV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FGEMV_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FGEMV_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/fgemv_pkg.sv
// Shared types and constants of the row-stream matrix-vector unit.
// No dependencies.
package fgemv_pkg;
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
   localparam logic [31:0] ZERO_BITS = 32'h0000_0000;
   localparam logic [31:0] NZERO_BITS = 32'h8000_0000;

   localparam int FMA_STAGES = 5;
   localparam int CSR_DATA_W = 16;

   localparam logic CSR_COLUMN_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT    = 1'b1;

   typedef struct packed {
      logic row0;
      logic last_row;
      logic last_col;
   } item_tag_type;
endpackage

FILE: design/fgemv_if.sv
// Item channels of the row-stream matrix-vector unit.
// No dependencies.
interface fgemv_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] vector_element;
   logic [31:0] matrix_element;
   modport source(output valid, vector_element, matrix_element, input ready);
   modport sink(input valid, vector_element, matrix_element, output ready);
endinterface

interface fgemv_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  column_index;
   logic [31:0] dot_result;
   logic        last_column;
   modport source(output valid, column_index, dot_result, last_column, input ready);
   modport sink(input valid, column_index, dot_result, last_column, output ready);
endinterface

FILE: design/fgemv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fgemv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/fgemv_fma.sv
// Five-stage binary32 fused multiply-add, nearest-even, with item tags.
// Depends on fgemv_pkg. Addend enters at stage 1, alongside the registered operands.
module fgemv_fma import fgemv_pkg::*; #(
   parameter int COL_W = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  item_tag_type                      in_tag,
   input  logic [COL_W-1:0]                  in_col,
   input  logic [31:0]                       in_a,
   input  logic [31:0]                       in_b,
   input  logic [31:0]                       s1_c,
   output logic [FMA_STAGES-1:0]             stage_valid,
   output logic [FMA_STAGES-1:0][COL_W-1:0]  stage_col,
   output logic                              out_valid,
   output item_tag_type                      out_tag,
   output logic [COL_W-1:0]                  out_col,
   output logic [31:0]                       out_result
);
   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n = 7'd64;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 7'(63 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   logic [FMA_STAGES-1:0]            v_ff;
   item_tag_type [FMA_STAGES-1:0]    tag_ff;
   logic [FMA_STAGES-1:0][COL_W-1:0] col_ff;
   logic [FMA_STAGES-1:0]            spec_ff;
   logic [FMA_STAGES-1:0][31:0]      specv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[FMA_STAGES-2:0], in_valid};
      end
   end

   // stage 1: unpack, multiply, special cases
   logic [31:0] a1_ff, b1_ff;
   logic [31:0] c1;
   logic        sp1, sc1;
   logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
   logic [23:0] ma, mb, mc;
   logic [7:0]  ea, eb, ec;
   logic        spec1;
   logic [31:0] specv1;

   always_comb begin
      c1 = tag_ff[0].row0 ? ZERO_BITS : s1_c;
      sp1 = a1_ff[31] ^ b1_ff[31];
      sc1 = c1[31];
      a_nan = a1_ff[30:0] > INF_BITS[30:0];
      b_nan = b1_ff[30:0] > INF_BITS[30:0];
      c_nan = c1[30:0] > INF_BITS[30:0];
      a_inf = a1_ff[30:0] == INF_BITS[30:0];
      b_inf = b1_ff[30:0] == INF_BITS[30:0];
      c_inf = c1[30:0] == INF_BITS[30:0];
      a_zero = a1_ff[30:0] == 31'd0;
      b_zero = b1_ff[30:0] == 31'd0;
      c_zero = c1[30:0] == 31'd0;
      ma = (a1_ff[30:23] == 8'd0) ? {1'b0, a1_ff[22:0]} : {1'b1, a1_ff[22:0]};
      mb = (b1_ff[30:23] == 8'd0) ? {1'b0, b1_ff[22:0]} : {1'b1, b1_ff[22:0]};
      mc = c_zero ? 24'd0 :
           ((c1[30:23] == 8'd0) ? {1'b0, c1[22:0]} : {1'b1, c1[22:0]});
      ea = (a1_ff[30:23] == 8'd0) ? 8'd1 : a1_ff[30:23];
      eb = (b1_ff[30:23] == 8'd0) ? 8'd1 : b1_ff[30:23];
      ec = (c1[30:23] == 8'd0) ? 8'd1 : c1[30:23];
      spec1 = 1'b1;
      specv1 = QNAN_BITS;
      if (a_nan || b_nan || c_nan) begin
         specv1 = QNAN_BITS;
      end else if (a_inf || b_inf) begin
         if (a_zero || b_zero) begin
            specv1 = QNAN_BITS;
         end else if (c_inf && (sc1 != sp1)) begin
            specv1 = QNAN_BITS;
         end else begin
            specv1 = {sp1, INF_BITS[30:0]};
         end
      end else if (c_inf) begin
         specv1 = c1;
      end else if (a_zero || b_zero) begin
         if (!c_zero) begin
            specv1 = c1;
         end else begin
            specv1 = (sp1 && sc1) ? NZERO_BITS : ZERO_BITS;
         end
      end else begin
         spec1 = 1'b0;
      end
   end

   // stage 2: normalize product and addend
   logic [47:0]        prod2_ff;
   logic signed [11:0] eab2_ff, ecc2_ff;
   logic [23:0]        mc2_ff;
   logic [2:1]         sp_ff, sc_ff, cz_ff;
   logic [6:0]         lzp, lzc;
   logic [61:0]        x2, y2;
   logic signed [11:0] ep2, ec2;

   always_comb begin
      lzp = lzc64({prod2_ff, 16'd0});
      lzc = lzc64({mc2_ff, 40'd0});
      x2 = {prod2_ff, 14'd0} << lzp;
      y2 = {mc2_ff, 38'd0} << lzc;
      ep2 = eab2_ff - $signed({5'd0, lzp});
      ec2 = ecc2_ff - $signed({5'd0, lzc});
   end

   // stage 3: swap, align, add
   logic [61:0]        x3_ff, y3_ff;
   logic signed [11:0] ep3_ff, ec3_ff;
   logic               swap;
   logic [61:0]        big, small_v, ys;
   logic signed [11:0] ebig, esmall, d;
   logic [123:0]       al_wide;
   logic               sx3;
   logic [62:0]        sum3;

   always_comb begin
      swap = !cz_ff[2] && ((ec3_ff > ep3_ff) || ((ec3_ff == ep3_ff) && (y3_ff > x3_ff)));
      big = swap ? y3_ff : x3_ff;
      small_v = swap ? x3_ff : y3_ff;
      ebig = swap ? ec3_ff : ep3_ff;
      esmall = swap ? ep3_ff : ec3_ff;
      sx3 = swap ? sc_ff[2] : sp_ff[2];
      d = ebig - esmall;
      al_wide = {small_v, 62'd0} >> d[5:0];
      if (cz_ff[2]) begin
         ys = 62'd0;
      end else if (d >= 12'sd63) begin
         ys = 62'd1;
      end else begin
         ys = al_wide[123:62] | {61'd0, |al_wide[61:0]};
      end
      if (sp_ff[2] == sc_ff[2]) begin
         sum3 = {1'b0, big} + {1'b0, ys};
      end else begin
         sum3 = {1'b0, big} - {1'b0, ys};
      end
   end

   // stage 4: normalize and align to the result grid
   logic [62:0]        sum4_ff;
   logic signed [11:0] e4_ff;
   logic               sx4_ff, zero4_ff;
   logic [6:0]         m4;
   logic signed [11:0] q4, sh4, ls4;
   logic [6:0]         shc;
   logic [62:0]        lsh;
   logic [126:0]       rs_wide;
   logic [24:0]        mant4;
   logic               rbit4, sticky4;

   always_comb begin
      m4 = 7'd62 - lzc64({sum4_ff, 1'b0});
      q4 = e4_ff + $signed({5'd0, m4}) - 12'sd23;
      if (q4 < -12'sd149) begin
         q4 = -12'sd149;
      end
      sh4 = q4 - e4_ff;
      ls4 = -sh4;
      shc = (sh4 > 12'sd64) ? 7'd64 : sh4[6:0];
      lsh = sum4_ff << ls4[5:0];
      rs_wide = {sum4_ff, 64'd0} >> shc;
      if (sh4 <= 12'sd0) begin
         mant4 = lsh[24:0];
         rbit4 = 1'b0;
         sticky4 = 1'b0;
      end else begin
         mant4 = rs_wide[88:64];
         rbit4 = rs_wide[63];
         sticky4 = |rs_wide[62:0];
      end
   end

   // stage 5: round and pack
   logic [24:0]        mant5_ff;
   logic               rbit5_ff, sticky5_ff, sx5_ff, zero5_ff;
   logic signed [11:0] q5_ff;
   logic [24:0]        mr, mn;
   logic signed [11:0] qn, biased;

   always_comb begin
      mr = mant5_ff + {24'd0, rbit5_ff && (sticky5_ff || mant5_ff[0])};
      mn = mr[24] ? (mr >> 1) : mr;
      qn = mr[24] ? (q5_ff + 12'sd1) : q5_ff;
      biased = mn[23] ? (qn + 12'sd150) : 12'sd0;
      if (spec_ff[4]) begin
         out_result = specv_ff[4];
      end else if (zero5_ff) begin
         out_result = ZERO_BITS;
      end else if (biased >= 12'sd255) begin
         out_result = {sx5_ff, INF_BITS[30:0]};
      end else begin
         out_result = {sx5_ff, biased[7:0], mn[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff <= {tag_ff[FMA_STAGES-2:0], in_tag};
         col_ff <= {col_ff[FMA_STAGES-2:0], in_col};
         spec_ff <= {spec_ff[FMA_STAGES-2:1], spec1, 1'b0};
         specv_ff <= {specv_ff[FMA_STAGES-2:1], specv1, ZERO_BITS};
         a1_ff <= in_a;
         b1_ff <= in_b;
         prod2_ff <= ma * mb;
         eab2_ff <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd314;
         ecc2_ff <= $signed({4'd0, ec}) - 12'sd188;
         mc2_ff <= mc;
         sp_ff <= {sp_ff[1], sp1};
         sc_ff <= {sc_ff[1], sc1};
         cz_ff <= {cz_ff[1], c_zero};
         x3_ff <= x2;
         y3_ff <= y2;
         ep3_ff <= ep2;
         ec3_ff <= ec2;
         sum4_ff <= sum3;
         e4_ff <= ebig;
         sx4_ff <= sx3;
         zero4_ff <= sum3 == 63'd0;
         mant5_ff <= mant4;
         rbit5_ff <= rbit4;
         sticky5_ff <= sticky4;
         q5_ff <= q4;
         sx5_ff <= sx4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   assign stage_valid = v_ff;
   assign stage_col = col_ff;
   assign out_valid = v_ff[FMA_STAGES-1];
   assign out_tag = tag_ff[FMA_STAGES-1];
   assign out_col = col_ff[FMA_STAGES-1];
endmodule

FILE: design/fp32_gemv_row_stream_unit.sv
// Streaming binary32 matrix-vector product c[j] = sum_k a[k]*b[k][j], top level.
// Depends on fgemv_pkg, fgemv_if, fgemv_ram, fgemv_fma and the assert macros.
//
// Matrix elements enter row-major, each with its row's vector element, one item
// per cycle unless the response output stalls. Each item goes through a
// five-stage fused multiply-add; column sums live in a RAM read at entry and
// written back when the item leaves the FMA. Row 0 items and any item whose
// column is not still inside the FMA are taken back to back. A later-row item
// whose column is still in flight waits until the earlier item leaves the FMA.
// Each last-row item yields one result, registered after it leaves the FMA.
// A register write restarts the product at row 0, column 0.
`include "fp32_gemv_row_stream_unit_assert.svh"
module fp32_gemv_row_stream_unit import fgemv_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   fgemv_req_if.sink             req_if,
   fgemv_rsp_if.source           rsp_if,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   logic [10:0]      column_count_ff;
   logic [15:0]      row_count_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      row_ff, row_in;
   logic [16:0]      ncol, ncol_m1;
   logic [15:0]      nrow_m1;
   logic             col_last, row_last, row0;
   logic             adv, hazard, accept;

   logic [FMA_STAGES-1:0]            stage_valid;
   logic [FMA_STAGES-1:0][COL_W-1:0] stage_col;
   logic                             f_valid;
   item_tag_type                     f_tag, in_tag;
   logic [COL_W-1:0]                 f_col;
   logic [31:0]                      f_result, ram_rdata;

   logic              rsp_valid_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [31:0]       rsp_result_ff;
   logic              rsp_last_ff;
   logic [31:0]       rsp_col_ext;

   always_comb begin
      ncol = {6'd0, column_count_ff};
      if (ncol == 17'd0) begin
         ncol = 17'd1;
      end else if (ncol > 17'(MAX_COLUMNS)) begin
         ncol = 17'(MAX_COLUMNS);
      end
      ncol_m1 = ncol - 17'd1;
      nrow_m1 = (row_count_ff == 16'd0) ? 16'd0 : (row_count_ff - 16'd1);
      col_last = 17'(col_ff) == ncol_m1;
      row_last = row_ff == nrow_m1;
      row0 = row_ff == 16'd0;
      hazard = 1'b0;
      for (int i = 0; i < FMA_STAGES; i++) begin
         if (stage_valid[i] && (stage_col[i] == col_ff)) begin
            hazard = 1'b1;
         end
      end
      in_tag = '{row0: row0, last_row: row_last, last_col: col_last};
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? 16'd0 : (row_ff + 16'd1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign adv = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv && (row0 || !hazard);
   assign accept = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 11'd1;
         row_count_ff <= 16'd1;
         col_ff <= '0;
         row_ff <= 16'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_wr_data[10:0];
            CSR_ROW_COUNT:    row_count_ff <= csr_wr_data[15:0];
            default:          row_count_ff <= row_count_ff;
         endcase
         col_ff <= '0;
         row_ff <= 16'd0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   fgemv_ram #(.WIDTH(32), .DEPTH(MAX_COLUMNS)) u_sums (
      .clock (clock),
      .we    (adv && f_valid),
      .waddr (f_col),
      .wdata (f_result),
      .re    (adv),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   fgemv_fma #(.COL_W(COL_W)) u_fma (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (accept),
      .in_tag      (in_tag),
      .in_col      (col_ff),
      .in_a        (req_if.vector_element),
      .in_b        (req_if.matrix_element),
      .s1_c        (ram_rdata),
      .stage_valid (stage_valid),
      .stage_col   (stage_col),
      .out_valid   (f_valid),
      .out_tag     (f_tag),
      .out_col     (f_col),
      .out_result  (f_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_valid && f_tag.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_col_ff <= f_col;
         rsp_result_ff <= f_result;
         rsp_last_ff <= f_tag.last_col;
      end
   end

   assign rsp_col_ext = 32'(rsp_col_ff);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.column_index = rsp_col_ext[9:0];
   assign rsp_if.dot_result = rsp_result_ff;
   assign rsp_if.last_column = rsp_last_ff;

   `FGEMV_ASSERT_IMP(a_col_range, clock, reset, 1'b1, 17'(col_ff) <= ncol_m1)
   `FGEMV_ASSERT_IMP(a_row_range, clock, reset, 1'b1, row_ff <= nrow_m1)
   `FGEMV_ASSERT_IMP(a_no_stale_read, clock, reset, accept && !row0 && adv && f_valid, f_col != col_ff)
   `FGEMV_ASSERT_NXT(a_stall_freeze, clock, reset, !adv && !csr_wr_en, $stable(stage_valid))
endmodule
